>>> hw/rtl/tkdr_pkg.sv
// Shared constants and types for the top-k degree ranking block.
// Used by tkdr_cell, tkdr_collect, top_k_degree_ranking_top and its bench; no dependencies.
package tkdr_pkg;

    // Default sizes of the ranking and its entries.
    localparam int RANK_DEPTH_DEF  = 100;
    localparam int ID_BITS_DEF     = 21;
    localparam int DEGREE_BITS_DEF = 21;

    // Width of the rank fields on the ports.
    localparam int POS_W = 7;

    // Cells per first-level group of the result reduction tree.
    localparam int GROUP_SIZE = 10;

    // Opcodes.
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Per-item bookkeeping that travels alongside the reduction tree.
    typedef struct packed {
        logic             vld;
        logic             rd;
        logic             placed;
        logic [POS_W-1:0] idx;
    } t_meta;

endpackage

>>> hw/rtl/tkdr_cell.sv
// One rank of the ranking: holds an (id, degree) entry and shifts it to its neighbor.
// Depends on tkdr_pkg; instantiated in a row by top_k_degree_ranking_top.
module tkdr_cell import tkdr_pkg::*; #(
    parameter int CELL_IDX    = 0,
    parameter int RANK_DEPTH  = RANK_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int DEGREE_BITS = DEGREE_BITS_DEF,
    parameter int TAP_W       = POS_W + ID_BITS + DEGREE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_offer,
    input  logic                   i_read,
    input  logic [ID_BITS-1:0]     i_id,
    input  logic [DEGREE_BITS-1:0] i_deg,
    input  logic [POS_W-1:0]       i_idx,
    input  logic [ID_BITS-1:0]     i_prev_id,
    input  logic [DEGREE_BITS-1:0] i_prev_deg,
    input  logic                   i_prev_exc,
    output logic [ID_BITS-1:0]     o_id,
    output logic [DEGREE_BITS-1:0] o_deg,
    output logic                   o_exc,
    output logic [TAP_W-1:0]       o_tap
);

    localparam logic [POS_W-1:0] MY_POS   = POS_W'(CELL_IDX);
    localparam bit               READABLE = (CELL_IDX < (2 ** POS_W));
    localparam bit               IS_LAST  = (CELL_IDX == RANK_DEPTH - 1);

    logic [ID_BITS-1:0]     r_id;
    logic [DEGREE_BITS-1:0] r_deg;
    logic [TAP_W-1:0]       r_tap;
    logic [ID_BITS-1:0]     n_id;
    logic [DEGREE_BITS-1:0] n_deg;
    logic [TAP_W-1:0]       n_tap;
    logic                   exc;
    logic                   hit;
    logic                   match;

    // The ranking is sorted, so once a cell is exceeded every cell below it is too.
    assign exc   = i_deg > r_deg;
    assign hit   = exc && !i_prev_exc;
    assign match = READABLE && (i_idx == MY_POS);

    always_comb begin
        n_id  = r_id;
        n_deg = r_deg;
        if (i_offer) begin
            if (i_prev_exc) begin
                n_id  = i_prev_id;
                n_deg = i_prev_deg;
            end else if (exc) begin
                n_id  = i_id;
                n_deg = i_deg;
            end
        end
    end

    // Tap into the reduction tree: a read shows the entry of the addressed cell; an
    // offer shows the insertion rank, and the last cell shows the entry it drops.
    always_comb begin
        n_tap = '0;
        if (i_read && match) begin
            n_tap = {{POS_W{1'b0}}, r_id, r_deg};
        end else if (i_offer) begin
            if (hit) begin
                n_tap[TAP_W-1 -: POS_W] = MY_POS;
            end
            if (IS_LAST && exc) begin
                n_tap[ID_BITS+DEGREE_BITS-1:0] = {r_id, r_deg};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= '0;
            r_deg <= '0;
            r_tap <= '0;
        end else begin
            r_id  <= n_id;
            r_deg <= n_deg;
            r_tap <= n_tap;
        end
    end

    assign o_id  = r_id;
    assign o_deg = r_deg;
    assign o_exc = exc;
    assign o_tap = r_tap;

    // The row stays sorted from high to low degree.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CELL_IDX == 0) || (r_deg <= i_prev_deg))
        else $error("rank cell out of order");

endmodule

>>> hw/rtl/tkdr_collect.sv
// Two-level registered OR tree that gathers the cell taps into one result word.
// Depends on tkdr_pkg; instantiated by top_k_degree_ranking_top.
module tkdr_collect import tkdr_pkg::*; #(
    parameter int RANK_DEPTH = RANK_DEPTH_DEF,
    parameter int TAP_W      = POS_W + ID_BITS_DEF + DEGREE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [RANK_DEPTH-1:0][TAP_W-1:0] i_taps,
    output logic [TAP_W-1:0]                 o_word
);

    localparam int NGRP = (RANK_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [NGRP-1:0][TAP_W-1:0] r_grp;
    logic [NGRP-1:0][TAP_W-1:0] n_grp;
    logic [TAP_W-1:0]           r_word;
    logic [TAP_W-1:0]           n_word;

    // At most one cell drives each field of a tap at a time, so OR merges them.
    always_comb begin
        n_grp = '0;
        for (int g = 0; g < NGRP; g++) begin
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < RANK_DEPTH) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb begin
        n_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_word = n_word | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp  <= '0;
            r_word <= '0;
        end else begin
            r_grp  <= n_grp;
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> hw/rtl/top_k_degree_ranking_top.sv
// Top-k degree ranking: a row of compare-and-shift cells holding the ranking.
// Each result is registered at the cell taps and in the OR tree, with its item's meta alongside.
// Throughput: one item per cycle; busy stays low, and the result strobe needs no ready.
// Rate is set by the cell row, which compares and shifts all ranks in the accept cycle.
// The cell taps then pass a two-stage OR tree to form the result.
// Synchronous active-low reset clears the ranking to zero and drops items in flight.
module top_k_degree_ranking_top import tkdr_pkg::*; #(
    parameter int RANK_DEPTH  = RANK_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_opcode,
    input  logic [ID_BITS-1:0]     i_node_id,
    input  logic [DEGREE_BITS-1:0] i_degree,
    input  logic [POS_W-1:0]       i_rank_index,
    output logic                   o_strobe,
    output logic                   o_placed,
    output logic [POS_W-1:0]       o_rank_pos,
    output logic [ID_BITS-1:0]     o_entry_id,
    output logic [DEGREE_BITS-1:0] o_entry_degree
);

    localparam int TAP_W = POS_W + ID_BITS + DEGREE_BITS;

    logic                             accept;
    logic                             offer;
    logic                             read;
    logic [RANK_DEPTH-1:0][TAP_W-1:0] taps;
    logic [TAP_W-1:0]                 word;
    logic [ID_BITS-1:0]               c_id  [RANK_DEPTH];
    logic [DEGREE_BITS-1:0]           c_deg [RANK_DEPTH];
    logic [RANK_DEPTH-1:0]            c_exc;
    t_meta                            n_meta;
    t_meta                            r_meta [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign offer  = accept && (i_opcode == OP_OFFER);
    assign read   = accept && (i_opcode == OP_READ);

    for (genvar g = 0; g < RANK_DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0]     p_id;
        logic [DEGREE_BITS-1:0] p_deg;
        logic                   p_exc;

        if (g == 0) begin : g_head
            assign p_id  = '0;
            assign p_deg = '1;
            assign p_exc = 1'b0;
        end else begin : g_body
            assign p_id  = c_id[g-1];
            assign p_deg = c_deg[g-1];
            assign p_exc = c_exc[g-1];
        end

        tkdr_cell #(
            .CELL_IDX   (g),
            .RANK_DEPTH (RANK_DEPTH),
            .ID_BITS    (ID_BITS),
            .DEGREE_BITS(DEGREE_BITS),
            .TAP_W      (TAP_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_offer   (offer),
            .i_read    (read),
            .i_id      (i_node_id),
            .i_deg     (i_degree),
            .i_idx     (i_rank_index),
            .i_prev_id (p_id),
            .i_prev_deg(p_deg),
            .i_prev_exc(p_exc),
            .o_id      (c_id[g]),
            .o_deg     (c_deg[g]),
            .o_exc     (c_exc[g]),
            .o_tap     (taps[g])
        );
    end

    tkdr_collect #(
        .RANK_DEPTH(RANK_DEPTH),
        .TAP_W     (TAP_W)
    ) u_collect (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_taps (taps),
        .o_word (word)
    );

    // The offer is taken exactly when the last rank is exceeded.
    always_comb begin
        n_meta        = '0;
        n_meta.vld    = accept;
        n_meta.rd     = read;
        n_meta.placed = offer && c_exc[RANK_DEPTH-1];
        n_meta.idx    = i_rank_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta[0] <= '0;
            r_meta[1] <= '0;
            r_meta[2] <= '0;
        end else begin
            r_meta[0] <= n_meta;
            r_meta[1] <= r_meta[0];
            r_meta[2] <= r_meta[1];
        end
    end

    assign o_strobe       = r_meta[2].vld;
    assign o_placed       = r_meta[2].placed;
    assign o_rank_pos     = r_meta[2].rd ? r_meta[2].idx : word[TAP_W-1 -: POS_W];
    assign o_entry_id     = word[DEGREE_BITS +: ID_BITS];
    assign o_entry_degree = word[DEGREE_BITS-1:0];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 3))
        else $error("result without a matching item");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_meta[2].rd && !o_placed) |->
        (o_rank_pos == '0 && o_entry_id == '0 && o_entry_degree == '0))
        else $error("rejected offer returned nonzero fields");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> (word == '0))
        else $error("reduction tree not empty while idle");

endmodule

>>> verif/top_k_degree_ranking_top_tb.sv
// Self-checking bench for top_k_degree_ranking_top: drives offers and rank reads with
// random idle gaps and checks every strobed result against a shadow copy of the ranking.
// Depends on tkdr_pkg and top_k_degree_ranking_top.
module top_k_degree_ranking_top_tb;
    import tkdr_pkg::*;

    localparam int DEPTH          = RANK_DEPTH_DEF;
    localparam int ID_W           = ID_BITS_DEF;
    localparam int DEG_W          = DEGREE_BITS_DEF;
    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 420;
    localparam logic [ID_W-1:0]  ID_MAX  = '1;
    localparam logic [DEG_W-1:0] DEG_MAX = '1;

    typedef struct packed {
        logic             placed;
        logic [POS_W-1:0] pos;
        logic [ID_W-1:0]  id;
        logic [DEG_W-1:0] deg;
    } t_rank_result;

    // Shadow ranking: predicts the result of each accepted item and checks what comes back.
    class t_ranking_shadow;
        logic [ID_W-1:0]  rank_id  [DEPTH];
        logic [DEG_W-1:0] rank_deg [DEPTH];
        t_rank_result     pending_results [$];
        int               mismatch_count;

        function new();
            foreach (rank_id[k]) begin
                rank_id[k]  = '0;
                rank_deg[k] = '0;
            end
            mismatch_count = 0;
        endfunction

        function void note_item(logic op, logic [ID_W-1:0] id, logic [DEG_W-1:0] deg,
                                logic [POS_W-1:0] idx);
            t_rank_result r;
            int           slot;
            r = '0;
            if (op == OP_READ) begin
                r.pos = idx;
                if (idx < DEPTH) begin
                    r.id  = rank_id[idx];
                    r.deg = rank_deg[idx];
                end
            end else if (deg > rank_deg[DEPTH-1]) begin
                r.placed = 1'b1;
                r.id     = rank_id[DEPTH-1];
                r.deg    = rank_deg[DEPTH-1];
                // Ties go after the existing entries of equal degree.
                slot = 0;
                while (slot < DEPTH-1 && !(deg > rank_deg[slot]))
                    slot++;
                for (int k = DEPTH-1; k > slot; k--) begin
                    rank_id[k]  = rank_id[k-1];
                    rank_deg[k] = rank_deg[k-1];
                end
                rank_id[slot]  = id;
                rank_deg[slot] = deg;
                r.pos = slot[POS_W-1:0];
            end
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(t_rank_result got);
            t_rank_result want;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result placed=%0b pos=%0d id=%0h deg=%0h",
                             $time, got.placed, got.pos, got.id, got.deg);
                return;
            end
            want = pending_results.pop_front();
            if (got.placed !== want.placed || got.pos !== want.pos ||
                got.id !== want.id || got.deg !== want.deg) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: mismatch exp placed=%0b pos=%0d id=%0h deg=%0h, %s",
                             $time, want.placed, want.pos, want.id, want.deg,
                             $sformatf("got placed=%0b pos=%0d id=%0h deg=%0h",
                                       got.placed, got.pos, got.id, got.deg));
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               i_opcode     = OP_OFFER;
    logic [ID_W-1:0]    i_node_id    = '0;
    logic [DEG_W-1:0]   i_degree     = '0;
    logic [POS_W-1:0]   i_rank_index = '0;
    logic               o_strobe;
    logic               o_placed;
    logic [POS_W-1:0]   o_rank_pos;
    logic [ID_W-1:0]    o_entry_id;
    logic [DEG_W-1:0]   o_entry_degree;

    t_ranking_shadow ranking;
    bit              idle_enable = 1'b1;
    int              quiet_cycles = 0;

    top_k_degree_ranking_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_node_id      (i_node_id),
        .i_degree       (i_degree),
        .i_rank_index   (i_rank_index),
        .o_strobe       (o_strobe),
        .o_placed       (o_placed),
        .o_rank_pos     (o_rank_pos),
        .o_entry_id     (o_entry_id),
        .o_entry_degree (o_entry_degree)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Values read here are those from before the edge, so acceptance needs no ordering.
    always @(posedge i_clk) begin : monitor_proc
        t_rank_result seen;
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (o_strobe) begin
                seen.placed = o_placed;
                seen.pos    = o_rank_pos;
                seen.id     = o_entry_id;
                seen.deg    = o_entry_degree;
                ranking.check_result(seen);
                quiet_cycles = 0;
            end
            if (start && !busy) begin
                ranking.note_item(i_opcode, i_node_id, i_degree, i_rank_index);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic drive_item(logic op, logic [ID_W-1:0] id, logic [DEG_W-1:0] deg,
                              logic [POS_W-1:0] idx);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 99) < 6)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_node_id    <= id;
        i_degree     <= deg;
        i_rank_index <= idx;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // The fields an item ignores still carry random values.
    task automatic offer_node(logic [ID_W-1:0] id, logic [DEG_W-1:0] deg);
        drive_item(OP_OFFER, id, deg, POS_W'($urandom));
    endtask

    task automatic read_rank(logic [POS_W-1:0] idx);
        drive_item(OP_READ, ID_W'($urandom), DEG_W'($urandom), idx);
    endtask

    task automatic random_item();
        int               pick;
        logic [DEG_W-1:0] deg;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            // Small degrees give ties early on, values near the top give ties at rank 0.
            case ($urandom_range(0, 4))
                0, 1:    deg = DEG_W'($urandom_range(0, 63));
                2:       deg = DEG_MAX - DEG_W'($urandom_range(0, 15));
                default: deg = DEG_W'($urandom);
            endcase
            offer_node(ID_W'($urandom), deg);
        end else if (pick < 90) begin
            read_rank(POS_W'($urandom_range(0, DEPTH-1)));
        end else begin
            read_rank(POS_W'($urandom_range(DEPTH, 127)));
        end
    endtask

    initial begin
        ranking = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The ranking starts all zero; reads beyond the last rank echo the index.
        read_rank(POS_W'(0));
        read_rank(POS_W'(DEPTH-1));
        read_rank(POS_W'(DEPTH));
        read_rank(POS_W'(127));
        offer_node(21'd5, '0);
        offer_node(ID_MAX, DEG_MAX);
        offer_node('0, 21'd1);
        offer_node(21'd7, 21'd1);
        offer_node(21'd8, 21'd1000);
        offer_node(21'd9, DEG_MAX);
        offer_node(21'h0AAAAA, 21'h155555);
        offer_node(21'h155555, 21'h0AAAAA);
        offer_node(21'd11, '0);
        for (int k = 0; k < 8; k++)
            read_rank(k[POS_W-1:0]);
        read_rank(POS_W'(DEPTH-1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_enable = !(n >= 150 && n < 280);
            random_item();
        end

        // Sweep the whole ranking once it has filled and churned.
        for (int k = 0; k < DEPTH; k++)
            read_rank(k[POS_W-1:0]);

        start <= 1'b0;
        while (ranking.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);

        if (ranking.mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
